// File: design/fdem_pkg.sv
// ----------------------------------------------------------------------------
// fdem_pkg
// Shared types, constants and helpers of the forward difference edge map.
// ----------------------------------------------------------------------------
package fdem_pkg;

   localparam int PIX_W      = 16;   // gray pixel
   localparam int EDGE_W     = 17;   // sum of two absolute differences
   localparam int CFG_W      = 10;   // width of the size registers
   localparam int ROW_W      = 9;    // line index
   localparam int MAX_COUNT  = 512;  // most lines per frame
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ITEM_DEPTH = 4;    // classified pixels between front and back
   localparam int RSP_DEPTH  = 2;    // results waiting for the consumer

   // register index, taken from csr address bit 2
   typedef enum logic {
      REG_LINE_LENGTH = 1'b0,
      REG_LINE_COUNT  = 1'b1
   } csr_reg_type;

   // one-hot result kinds, in emission order
   localparam logic [2:0] SEL_BELOW  = 3'b001;  // result of the pixel above
   localparam logic [2:0] SEL_LEFT   = 3'b010;  // last line, pixel to the left
   localparam logic [2:0] SEL_CORNER = 3'b100;  // frame corner, passes unchanged

   typedef struct packed {
      logic has_right;   // pixel above has a right neighbor
      logic corner;
      logic has_left;
      logic has_below;
   } flags_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] prev;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] right;
      flags_type        flags;
   } item_type;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_value;
      logic              last_of_run;
      logic              end_of_frame;
   } result_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: design/fdem_fifo.sv
// ----------------------------------------------------------------------------
// fdem_fifo
// Small register queue with occupancy count; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module fdem_fifo import fdem_pkg::*; #(
   parameter type ENTRY_type = logic,
   parameter int  DEPTH      = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ENTRY_type                  wdata,
   output logic                       full,
   input  logic                       pop,
   output ENTRY_type                  rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int LvlW = $clog2(DEPTH+1);

   ENTRY_type           entries_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == LvlW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign level   = count_ff;
   assign rdata   = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + LvlW'(do_push) - LvlW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: design/fdem_front.sv
// ----------------------------------------------------------------------------
// fdem_front
// Scan position tracking, pixel classification and the line buffer.
// ----------------------------------------------------------------------------
module fdem_front import fdem_pkg::*; #(
   parameter int MAX_LINE = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,      // size register written
   input  logic [CFG_W-1:0] line_length,
   input  logic [CFG_W-1:0] line_count,
   input  logic             accept,
   input  logic [PIX_W-1:0] pixel,
   output logic             item_valid,
   output item_type         item
);

   localparam int ColW = $clog2(MAX_LINE);
   localparam int LenW = (CFG_W > $clog2(MAX_LINE+1)) ? CFG_W : $clog2(MAX_LINE+1);

   logic [PIX_W-1:0] line_mem [MAX_LINE];

   logic [ColW-1:0]  col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] prev_ff, prev_in;
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [PIX_W-1:0] s1_prev_ff;
   flags_type        s1_flags_ff;
   logic [PIX_W-1:0] above_ff;
   logic [PIX_W-1:0] right_ff;

   logic [LenW-1:0]  len_raw, width, col_next;
   logic [CFG_W-1:0] height;
   logic             last_col, last_row;
   flags_type        flags;
   logic [ColW-1:0]  right_addr;

   // clamp sizes: zero acts as one
   always_comb begin
      len_raw = LenW'(line_length);
      if (len_raw == '0) begin
         width = LenW'(1);
      end else if (len_raw > LenW'(MAX_LINE)) begin
         width = LenW'(MAX_LINE);
      end else begin
         width = len_raw;
      end
      if (line_count == '0) begin
         height = CFG_W'(1);
      end else if (line_count > CFG_W'(MAX_COUNT)) begin
         height = CFG_W'(MAX_COUNT);
      end else begin
         height = line_count;
      end
   end

   always_comb begin
      col_next        = LenW'(col_ff) + LenW'(1);
      last_col        = (col_next == width);
      last_row        = ({1'b0, row_ff} == (height - CFG_W'(1)));
      flags.has_below = (row_ff != '0);
      flags.has_right = (col_next < width);
      flags.has_left  = last_row && (col_ff != '0);
      flags.corner    = last_row && last_col;
      right_addr      = flags.has_right ? col_ff + 1'b1 : col_ff;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      prev_in = prev_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         prev_in = pixel;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         prev_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         prev_ff     <= prev_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= pixel;
         s1_prev_ff  <= prev_ff;
         s1_flags_ff <= flags;
      end
   end

   // line buffer: old values read before the current pixel overwrites its column
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff         <= line_mem[col_ff];
         right_ff         <= line_mem[right_addr];
         line_mem[col_ff] <= pixel;
      end
   end

   assign item_valid  = s1_valid_ff;
   assign item.pixel  = s1_pixel_ff;
   assign item.prev   = s1_prev_ff;
   assign item.above  = above_ff;
   assign item.right  = right_ff;
   assign item.flags  = s1_flags_ff;

endmodule

// File: design/fdem_back.sv
// ----------------------------------------------------------------------------
// fdem_back
// Expands one classified pixel into its zero to three results.
// ----------------------------------------------------------------------------
module fdem_back import fdem_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_data
);

   logic [2:0]        done_ff, done_in;
   logic [2:0]        pend, sel, rest;
   logic [EDGE_W-1:0] below_sum;

   always_comb begin
      pend = {item.flags.corner, item.flags.has_left, item.flags.has_below} & ~done_ff;
      sel  = pend & (~pend + 3'd1);   // lowest pending kind goes first
      rest = pend & ~sel;
   end

   always_comb begin
      below_sum = EDGE_W'(abs_diff(item.pixel, item.above));
      if (item.flags.has_right) begin
         below_sum = below_sum + EDGE_W'(abs_diff(item.right, item.above));
      end
   end

   always_comb begin
      out_data.last_of_run  = (rest == '0);
      out_data.end_of_frame = 1'b0;
      unique case (sel)
         SEL_BELOW: out_data.edge_value = below_sum;
         SEL_LEFT:  out_data.edge_value = EDGE_W'(abs_diff(item.pixel, item.prev));
         SEL_CORNER: begin
            out_data.edge_value   = EDGE_W'(item.pixel);
            out_data.end_of_frame = 1'b1;
         end
         default:   out_data.edge_value = '0;
      endcase
   end

   always_comb begin
      out_push = 1'b0;
      item_pop = 1'b0;
      done_in  = done_ff;
      if (item_valid) begin
         if (pend == '0) begin
            item_pop = 1'b1;
            done_in  = '0;
         end else if (!out_full) begin
            out_push = 1'b1;
            if (rest == '0) begin
               item_pop = 1'b1;
               done_in  = '0;
            end else begin
               done_in = done_ff | sel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

// File: design/forward_difference_edge_map.sv
// ----------------------------------------------------------------------------
// forward_difference_edge_map
// Streaming L1 forward-difference edge map over a gray frame.
// ----------------------------------------------------------------------------
// Pixels are pushed in line order, one transfer each; the block accepts one
// pixel per cycle while req_full is low. Each pixel's result is |below - here|
// + |right - here|, the right term only where it exists, and leaves when the
// pixel below it arrives. On the last line the same-line difference follows
// with a lag of one pixel, and the frame corner passes unchanged with
// end_of_frame set; last_of_run marks the final result a pixel causes. Results
// leave one per cycle while the result queue has room, so on the last line,
// where a pixel can cause two results, the result port limits the rate. The
// line buffer is a MAX_LINE x 16 memory with one write and two registered reads
// per cycle; it needs no clearing pass. Writing either size register restarts
// the frame at its first pixel; the buffer keeps its contents.
// ----------------------------------------------------------------------------
module forward_difference_edge_map import fdem_pkg::*; #(
   parameter int MAX_LINE = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input queue
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [PIX_W-1:0]      req_pixel,
   // result output queue
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [EDGE_W-1:0]     rsp_edge_value,
   output logic                  rsp_last_of_run,
   output logic                  rsp_end_of_frame,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ItemLvlW = $clog2(ITEM_DEPTH+1);

   // size registers
   logic [CFG_W-1:0] line_length_ff, line_length_in;
   logic [CFG_W-1:0] line_count_ff, line_count_in;
   csr_reg_type      csr_reg;
   logic             csr_wr;

   // front to back
   logic             accept;
   logic             s1_valid;
   item_type         s1_item;
   item_type         head_item;
   logic             item_empty;
   logic             item_pop;
   logic [ItemLvlW-1:0] item_level;

   // back to result queue
   logic             out_push;
   logic             out_full;
   result_type       out_data;
   result_type       rsp_head;

   // ---------------------------------------------------------------------
   // Register port: address bit 2 picks the register, pready tied high.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      line_length_in = line_length_ff;
      line_count_in  = line_count_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            REG_LINE_LENGTH: line_length_in = csr_pwdata[CFG_W-1:0];
            REG_LINE_COUNT:  line_count_in  = csr_pwdata[CFG_W-1:0];
            default:         line_length_in = line_length_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_LINE_LENGTH: csr_prdata = CSR_DATA_W'(line_length_ff);
         REG_LINE_COUNT:  csr_prdata = CSR_DATA_W'(line_count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= CFG_W'(512);
         line_count_ff  <= CFG_W'(512);
      end else begin
         line_length_ff <= line_length_in;
         line_count_ff  <= line_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input side. The front's stage register always drains into the item
   // queue next cycle, so it counts against the queue's free slots.
   // ---------------------------------------------------------------------
   assign req_full = ({1'b0, item_level} + {{ItemLvlW{1'b0}}, s1_valid})
                     >= (ItemLvlW+1)'(ITEM_DEPTH);
   assign accept   = req_push && !req_full;

   fdem_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_wr),
      .line_length (line_length_ff),
      .line_count  (line_count_ff),
      .accept      (accept),
      .pixel       (req_pixel),
      .item_valid  (s1_valid),
      .item        (s1_item)
   );

   // classified pixels, decoupling the front from result back-pressure
   fdem_fifo #(
      .ENTRY_type (item_type),
      .DEPTH      (ITEM_DEPTH)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (s1_valid),
      .wdata (s1_item),
      .full  (),
      .pop   (item_pop),
      .rdata (head_item),
      .empty (item_empty),
      .level (item_level)
   );

   // ---------------------------------------------------------------------
   // Back side: one result per cycle into the result queue, while it has room.
   // ---------------------------------------------------------------------
   fdem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!item_empty),
      .item       (head_item),
      .item_pop   (item_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   fdem_fifo #(
      .ENTRY_type (result_type),
      .DEPTH      (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty),
      .level ()
   );

   assign rsp_edge_value   = rsp_head.edge_value;
   assign rsp_last_of_run  = rsp_head.last_of_run;
   assign rsp_end_of_frame = rsp_head.end_of_frame;

endmodule

// File: design/fdem_checker.sv
// ----------------------------------------------------------------------------
// fdem_checker
// Port-level checks of the edge map, bound to the top level.
// ----------------------------------------------------------------------------
module fdem_checker import fdem_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [EDGE_W-1:0]     rsp_edge_value,
   input logic                  rsp_last_of_run,
   input logic                  rsp_end_of_frame,
   input logic                  csr_pready
);

   // reset drops every waiting result
   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // corner result closes the pixel's run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_frame) |-> rsp_last_of_run)
      else $error("end_of_frame without last_of_run");

   // corner passes a raw pixel, never a sum
   a_eof_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_frame) |-> !rsp_edge_value[EDGE_W-1])
      else $error("corner value out of pixel range");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_edge_value)
         && $stable(rsp_last_of_run) && $stable(rsp_end_of_frame)))
      else $error("result changed while waiting");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind forward_difference_edge_map fdem_checker u_checker (.*);
